>>> hw/rtl/bb3_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the 3x3 box blur.
// No dependencies; imported by the top level and by its port checker.
package bb3_pkg;

	// Line store depth and derived index widths
	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int EW_W      = $clog2(MAX_WIDTH + 1);

	// Field and register widths
	localparam int CH_W       = 8;
	localparam int PIX_W      = 3 * CH_W;
	localparam int FW_W       = 11;
	localparam int FH_W       = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	// Window sum and divide widths
	localparam int SUM_W    = 12;
	localparam int N_W      = 4;
	localparam int T_W      = SUM_W + 1;
	localparam int DIV_K    = 18;
	localparam int RECIP_W  = DIV_K;
	localparam int PROD_W   = T_W + RECIP_W;

	// Reset values of the frame size registers
	localparam int FRAME_WIDTH_RST  = 640;
	localparam int FRAME_HEIGHT_RST = 480;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

	// Beat commands
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// Reciprocals ceil(2^K / 2n) for each possible neighbour count n
	localparam int RECIP_1 = (2 ** DIV_K + 2 - 1) / 2;
	localparam int RECIP_2 = (2 ** DIV_K + 4 - 1) / 4;
	localparam int RECIP_3 = (2 ** DIV_K + 6 - 1) / 6;
	localparam int RECIP_4 = (2 ** DIV_K + 8 - 1) / 8;
	localparam int RECIP_6 = (2 ** DIV_K + 12 - 1) / 12;
	localparam int RECIP_9 = (2 ** DIV_K + 18 - 1) / 18;

	// Multiplier that turns (2*sum + n) into the rounded mean after >> DIV_K
	function automatic logic [RECIP_W-1:0] recip(input logic [N_W-1:0] n);
		logic [RECIP_W-1:0] m;
		case (n)
			N_W'(2): m = RECIP_W'(RECIP_2);
			N_W'(3): m = RECIP_W'(RECIP_3);
			N_W'(4): m = RECIP_W'(RECIP_4);
			N_W'(6): m = RECIP_W'(RECIP_6);
			N_W'(9): m = RECIP_W'(RECIP_9);
			default: m = RECIP_W'(RECIP_1);
		endcase
		return m;
	endfunction

	// Zero width reads as one, oversize width saturates at the line store depth
	function automatic logic [EW_W-1:0] eff_width(input logic [FW_W-1:0] fw);
		logic [EW_W-1:0] w;
		if (fw == '0) begin
			w = EW_W'(1);
		end else if (int'(fw) > MAX_WIDTH) begin
			w = EW_W'(MAX_WIDTH);
		end else begin
			w = EW_W'(fw);
		end
		return w;
	endfunction

	// Zero height reads as one
	function automatic logic [FH_W-1:0] eff_height(input logic [FH_W-1:0] fh);
		return (fh == '0) ? FH_W'(1) : fh;
	endfunction

endpackage

>>> hw/rtl/box_blur_3x3_edge_average_top.sv
`timescale 1ns / 1ps
// 3x3 box blur with edge-aware averaging over a raster-order RGB stream.
// Depends on bb3_pkg for widths, register indexes and the divide reciprocals.

// Pixels enter in raster order on the pixel channel (command 0), and one
// blurred pixel leaves per transfer on the result channel; the block sustains
// one input transfer per clock unless stalled, limited by the single write and
// single registered read of the line store and the window update done on every
// transfer. A result passes the stage 1 and stage 2 registers after the beat
// completing its window; the output trails the input by one row plus one pixel.
// After the last pixel of a frame, send width+1 flush beats (command 1) to
// drain the final row; the result for the frame's last pixel has frame_last
// set. Beats whose command does not fit the frame's phase are consumed and
// dropped. Each output channel is the mean over the in-frame neighbours,
// rounded to nearest with ties upward. Writing frame_width or frame_height
// aborts the frame in progress. The line store is not cleared after reset;
// entries never written only feed window positions outside the frame.
module box_blur_3x3_edge_average_top (
	input  logic                             clk,
	input  logic                             arst_n,
	// pixel channel
	input  logic                             pixel_valid,
	output logic                             pixel_stall,
	input  logic                             command,
	input  logic [bb3_pkg::CH_W-1:0]         blue_in,
	input  logic [bb3_pkg::CH_W-1:0]         green_in,
	input  logic [bb3_pkg::CH_W-1:0]         red_in,
	// result channel
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic [bb3_pkg::CH_W-1:0]         blue_out,
	output logic [bb3_pkg::CH_W-1:0]         green_out,
	output logic [bb3_pkg::CH_W-1:0]         red_out,
	output logic                             frame_last,
	// configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bb3_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bb3_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import bb3_pkg::*;

	// frame size (stored already clamped) and raster position
	logic [EW_W-1:0]        eff_w_q;
	logic [FH_W-1:0]        eff_h_q;
	logic [COL_W-1:0]       col_q, col_d;
	logic [FH_W-1:0]        row_q, row_d;
	logic [EW_W-1:0]        flush_q, flush_d;

	// beat decode
	logic                   cfg_we, cfg_hit;
	logic                   xfer, take, phase_pix, end_case, do_shift;
	logic [EW_W-1:0]        pos, col_inc;
	logic [COL_W-1:0]       wr_col, rd_addr;
	logic                   emit, last_d;
	logic [2:0]             row_m, col_m;
	logic                   w_gt1, row_ge1, row_ge2, row_ge3, pos_ge2;

	// line store: {upper, middle} per column
	logic [2*PIX_W-1:0]     line_mem [MAX_WIDTH];
	logic [2*PIX_W-1:0]     mem_rd_q, byp_data_q, line_rd, wr_data;
	logic                   byp_q, mem_we;
	logic [PIX_W-1:0]       rd_upper, rd_middle, pix_new;

	// window
	logic [PIX_W-1:0]       win_q [3][3];
	logic [PIX_W-1:0]       nw    [3][3];
	logic [PIX_W-1:0]       col_v [3];
	logic [SUM_W-1:0]       row_sum [3][3];
	logic [SUM_W-1:0]       sum_d [3];
	logic [N_W-1:0]         n_d;

	// pipeline
	logic                   valid_s1, last_s1;
	logic [SUM_W-1:0]       sum_s1 [3];
	logic [N_W-1:0]         n_s1;
	logic                   valid_s2, last_s2;
	logic [CH_W-1:0]        chan_s2 [3];
	logic [CH_W-1:0]        quot [3];
	logic [T_W-1:0]         num [3];
	logic [PROD_W-1:0]      prod [3];
	logic                   s1_ready, s2_ready;

	// handshakes
	assign cfg_ready   = 1'b1;
	assign cfg_we      = cfg_valid && cfg_ready;
	assign cfg_hit     = cfg_we && (cfg_index == REG_FRAME_WIDTH ||
	                                cfg_index == REG_FRAME_HEIGHT);
	assign s2_ready    = !valid_s2 || !result_stall;
	assign s1_ready    = !valid_s1 || s2_ready;
	assign pixel_stall = !s1_ready;
	assign xfer        = pixel_valid && !pixel_stall;

	// phase of the frame and what this beat does
	assign phase_pix = row_q < eff_h_q;
	assign end_case  = !phase_pix && (flush_q == eff_w_q);
	assign do_shift  = !end_case;
	assign take      = xfer && (command == (phase_pix ? CMD_PIXEL : CMD_FLUSH));
	// one of col_q / flush_q is always zero, so OR gives the active column
	assign pos       = EW_W'(col_q) | flush_q;
	assign wr_col    = col_q | flush_q[COL_W-1:0];
	assign col_inc   = EW_W'(col_q) + EW_W'(1);

	assign w_gt1   = eff_w_q > EW_W'(1);
	assign row_ge1 = row_q != '0;
	assign row_ge2 = row_q >= FH_W'(2);
	assign row_ge3 = row_q >= FH_W'(3);
	assign pos_ge2 = pos >= EW_W'(2);

	// Window masks for the emitted pixel. Bit 0 is top row / left column.
	// The frame's final pixel is taken from the unshifted window, centered in
	// column 2; every other result is centered in column 1 after the shift.
	always_comb begin
		if (end_case) begin
			emit   = 1'b1;
			row_m  = {1'b0, 1'b1, row_ge2};
			col_m  = {1'b1, w_gt1, 1'b0};
			last_d = 1'b1;
		end else if (pos == '0) begin
			// start of a row: finish the last pixel of the row two above
			emit   = row_ge2;
			row_m  = {1'b1, 1'b1, row_ge3};
			col_m  = {1'b0, 1'b1, w_gt1};
			last_d = 1'b0;
		end else begin
			emit   = row_ge1;
			row_m  = {phase_pix, 1'b1, row_ge2};
			col_m  = {1'b1, 1'b1, pos_ge2};
			last_d = 1'b0;
		end
	end

	// next raster position
	always_comb begin
		col_d   = col_q;
		row_d   = row_q;
		flush_d = flush_q;
		if (cfg_hit) begin
			col_d   = '0;
			row_d   = '0;
			flush_d = '0;
		end else if (take) begin
			if (phase_pix) begin
				if (col_inc >= eff_w_q) begin
					col_d   = '0;
					row_d   = row_q + FH_W'(1);
					flush_d = '0;
				end else begin
					col_d = col_inc[COL_W-1:0];
				end
			end else if (do_shift) begin
				flush_d = flush_q + EW_W'(1);
			end else begin
				col_d   = '0;
				row_d   = '0;
				flush_d = '0;
			end
		end
	end

	// configuration and position registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q <= eff_width(FW_W'(FRAME_WIDTH_RST));
			eff_h_q <= eff_height(FH_W'(FRAME_HEIGHT_RST));
			col_q   <= '0;
			row_q   <= '0;
			flush_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_WIDTH:  eff_w_q <= eff_width(cfg_data[FW_W-1:0]);
					REG_FRAME_HEIGHT: eff_h_q <= eff_height(cfg_data[FH_W-1:0]);
					default: ;
				endcase
			end
			col_q   <= col_d;
			row_q   <= row_d;
			flush_q <= flush_d;
		end
	end

	// Line store: write the shifted column, prefetch the next beat's column
	assign pix_new = phase_pix ? {red_in, green_in, blue_in} : '0;
	assign mem_we  = take && do_shift;
	assign rd_addr = col_d | flush_d[COL_W-1:0];
	assign wr_data = {rd_middle, pix_new};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_mem[wr_col] <= wr_data;
		end
		mem_rd_q <= line_mem[rd_addr];
	end

	// write-to-read bypass for one-column frames
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= mem_we && (wr_col == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= wr_data;
	end

	assign line_rd   = byp_q ? byp_data_q : mem_rd_q;
	assign rd_upper  = line_rd[2*PIX_W-1:PIX_W];
	assign rd_middle = line_rd[PIX_W-1:0];

	// window after this beat
	assign col_v[0] = rd_upper;
	assign col_v[1] = rd_middle;
	assign col_v[2] = pix_new;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			if (do_shift) begin
				nw[r][0] = win_q[r][1];
				nw[r][1] = win_q[r][2];
				nw[r][2] = col_v[r];
			end else begin
				for (int c = 0; c < 3; c++) begin
					nw[r][c] = win_q[r][c];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (take) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= nw[r][c];
				end
			end
		end
	end

	// masked per-channel sums: row sums first, then the three rows
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			sum_d[ch] = '0;
			for (int r = 0; r < 3; r++) begin
				row_sum[r][ch] = '0;
				for (int c = 0; c < 3; c++) begin
					if (row_m[r] && col_m[c]) begin
						row_sum[r][ch] = row_sum[r][ch] +
						                 SUM_W'(nw[r][c][ch*CH_W +: CH_W]);
					end
				end
				sum_d[ch] = sum_d[ch] + row_sum[r][ch];
			end
		end
	end

	assign n_d = N_W'($countones(row_m) * $countones(col_m));

	// stage 1: sums and neighbour count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= take && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && take && emit) begin
			for (int ch = 0; ch < 3; ch++) begin
				sum_s1[ch] <= sum_d[ch];
			end
			n_s1    <= n_d;
			last_s1 <= last_d;
		end
	end

	// rounded mean: (2*sum + n) times ceil(2^K / 2n), then >> K (exact here)
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			num[ch]  = T_W'({sum_s1[ch], 1'b0}) + T_W'(n_s1);
			prod[ch] = PROD_W'(num[ch]) * PROD_W'(recip(n_s1));
			quot[ch] = prod[ch][DIV_K +: CH_W];
		end
	end

	// stage 2: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && valid_s1) begin
			for (int ch = 0; ch < 3; ch++) begin
				chan_s2[ch] <= quot[ch];
			end
			last_s2 <= last_s1;
		end
	end

	assign result_valid = valid_s2;
	assign blue_out     = chan_s2[0];
	assign green_out    = chan_s2[1];
	assign red_out      = chan_s2[2];
	assign frame_last   = last_s2;

endmodule

>>> hw/rtl/bb3_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the 3x3 box blur top level, and its bind.
// Depends on bb3_pkg for port widths.
module bb3_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             pixel_valid,
	input logic                             pixel_stall,
	input logic                             command,
	input logic [bb3_pkg::CH_W-1:0]         blue_in,
	input logic [bb3_pkg::CH_W-1:0]         green_in,
	input logic [bb3_pkg::CH_W-1:0]         red_in,
	input logic                             result_valid,
	input logic                             result_stall,
	input logic [bb3_pkg::CH_W-1:0]         blue_out,
	input logic [bb3_pkg::CH_W-1:0]         green_out,
	input logic [bb3_pkg::CH_W-1:0]         red_out,
	input logic                             frame_last,
	input logic                             cfg_valid,
	input logic                             cfg_ready,
	input logic [bb3_pkg::CFG_IDX_W-1:0]    cfg_index,
	input logic [bb3_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import bb3_pkg::*;

	logic pix_xfer;
	assign pix_xfer = pixel_valid && !pixel_stall;

	// a held result keeps its payload until transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid &&
		$stable(blue_out) && $stable(green_out) && $stable(red_out) &&
		$stable(frame_last))
	else $error("result changed while stalled");

	// the input only backs up when a result is waiting and held
	assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> result_valid && result_stall)
	else $error("pixel channel stalled with output free");

	// a fresh result always comes from an earlier pixel transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(pix_xfer, 2))
	else $error("result appeared without a matching pixel transfer");

	// with the output empty and nothing taken in, the pipeline drains
	assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid && !pix_xfer |=> !pixel_stall)
	else $error("pixel channel stalled after pipeline drained");

endmodule

bind box_blur_3x3_edge_average_top bb3_checker u_bb3_checker (.*);

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for box_blur_3x3_edge_average_top: a scoreboard class predicts
// every blurred pixel from the accepted beats and checks the result stream against it.
// Depends on bb3_pkg for widths, register indexes and beat commands.
module tb;
	import bb3_pkg::*;

	localparam int SENDER          = 0;
	localparam int RECEIVER        = 1;
	localparam int LONG_HOLD       = 300;
	localparam int DRAIN_CYCLES    = 8;
	localparam int CYCLE_LIMIT     = 1000000;
	localparam int RANDOM_ITEMS    = 300;
	localparam int PRESSURE_FRAME  = 1;
	localparam int SAT_FLUSH_BEATS = 8;

	// indexes past the register map, writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = CFG_IDX_W'(3);

	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
		logic            last;
	} blur_result_t;

	// Predicts the blurred pixels from accepted beats and checks the output against them
	class blur_scoreboard;
		logic [FW_W-1:0]  width_reg;
		logic [FH_W-1:0]  height_reg;
		logic [PIX_W-1:0] upper_row [MAX_WIDTH];
		logic [PIX_W-1:0] middle_row [MAX_WIDTH];
		logic [PIX_W-1:0] window [9];
		int               col_pos;
		int               row_pos;
		int               flush_pos;
		blur_result_t     expected_pixels [$];
		int               errors;

		function new();
			width_reg  = FW_W'(FRAME_WIDTH_RST);
			height_reg = FH_W'(FRAME_HEIGHT_RST);
			foreach (upper_row[i]) begin
				upper_row[i]  = '0;
				middle_row[i] = '0;
			end
			foreach (window[i]) window[i] = '0;
			col_pos   = 0;
			row_pos   = 0;
			flush_pos = 0;
			errors    = 0;
		endfunction

		// zero reads as one, oversize saturates at the line store depth
		function int active_width();
			int w;
			w = int'(width_reg);
			if (w == 0) w = 1;
			if (w > MAX_WIDTH) w = MAX_WIDTH;
			return w;
		endfunction

		function int active_height();
			return (height_reg == '0) ? 1 : int'(height_reg);
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction

		// any mapped write aborts the frame in progress
		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_FRAME_WIDTH) begin
				width_reg = data[FW_W-1:0];
			end else if (idx == REG_FRAME_HEIGHT) begin
				height_reg = data[FH_W-1:0];
			end else begin
				return;
			end
			col_pos   = 0;
			row_pos   = 0;
			flush_pos = 0;
		endfunction

		// read one column from the line stores, rotate them, shift the window left
		function void shift_column(int col, logic [PIX_W-1:0] pix);
			logic [PIX_W-1:0] v [3];
			if (col >= MAX_WIDTH) col = MAX_WIDTH - 1;
			v[0] = upper_row[col];
			v[1] = middle_row[col];
			v[2] = pix;
			upper_row[col]  = v[1];
			middle_row[col] = v[2];
			for (int r = 0; r < 3; r++) begin
				window[r*3 + 0] = window[r*3 + 1];
				window[r*3 + 1] = window[r*3 + 2];
				window[r*3 + 2] = v[r];
			end
		endfunction

		// mean over in-frame neighbours of (qr, qc); centre sits in window column cc
		function void push_mean(int cc, int qr, int qc, int h, int w);
			int s_blue, s_green, s_red, n, row, col, wc;
			logic [PIX_W-1:0] p;
			blur_result_t res;
			s_blue  = 0;
			s_green = 0;
			s_red   = 0;
			n       = 0;
			for (int dr = -1; dr <= 1; dr++) begin
				row = qr + dr;
				if (row < 0 || row >= h) continue;
				for (int dc = -1; dc <= 1; dc++) begin
					col = qc + dc;
					wc  = cc + dc;
					if (col < 0 || col >= w || wc < 0 || wc >= 3) continue;
					p = window[(dr + 1)*3 + wc];
					s_blue  += int'(p[CH_W-1:0]);
					s_green += int'(p[2*CH_W-1:CH_W]);
					s_red   += int'(p[3*CH_W-1:2*CH_W]);
					n++;
				end
			end
			if (n == 0) n = 1;
			// round half up, exact in integers
			res.blue  = CH_W'((2*s_blue + n) / (2*n));
			res.green = CH_W'((2*s_green + n) / (2*n));
			res.red   = CH_W'((2*s_red + n) / (2*n));
			res.last  = (qr == h - 1 && qc == w - 1);
			expected_pixels.push_back(res);
		endfunction

		// called on every accepted beat; beats out of phase leave no trace
		function void note_beat(logic cmd, logic [CH_W-1:0] b, logic [CH_W-1:0] g,
				logic [CH_W-1:0] r);
			logic [PIX_W-1:0] pix;
			int w, h;
			pix = {r, g, b};
			w = active_width();
			h = active_height();
			if (row_pos < h) begin
				if (cmd != CMD_PIXEL) return;
				if (col_pos == 0) begin
					if (row_pos >= 2) push_mean(2, row_pos - 2, w - 1, h, w);
					shift_column(0, pix);
				end else begin
					shift_column(col_pos, pix);
					if (row_pos >= 1) push_mean(1, row_pos - 1, col_pos - 1, h, w);
				end
				col_pos++;
				if (col_pos >= w) begin
					col_pos = 0;
					row_pos++;
					flush_pos = 0;
				end
			end else begin
				if (cmd != CMD_FLUSH) return;
				if (flush_pos == 0) begin
					if (h >= 2) push_mean(2, h - 2, w - 1, h, w);
					shift_column(0, '0);
					flush_pos++;
				end else if (flush_pos < w) begin
					shift_column(flush_pos, '0);
					push_mean(1, h - 1, flush_pos - 1, h, w);
					flush_pos++;
				end else begin
					push_mean(2, h - 1, w - 1, h, w);
					col_pos   = 0;
					row_pos   = 0;
					flush_pos = 0;
				end
			end
		endfunction

		// compare one result transfer with the oldest prediction
		function void check_result(logic [CH_W-1:0] b, logic [CH_W-1:0] g,
				logic [CH_W-1:0] r, logic last);
			blur_result_t want;
			if (expected_pixels.size() == 0) begin
				$error("unexpected result: blue_out %0d green_out %0d red_out %0d frame_last %0d",
					b, g, r, last);
				errors++;
				return;
			end
			want = expected_pixels.pop_front();
			if (b !== want.blue) begin
				$error("blue_out: expected %0d, actual %0d", want.blue, b);
				errors++;
			end
			if (g !== want.green) begin
				$error("green_out: expected %0d, actual %0d", want.green, g);
				errors++;
			end
			if (r !== want.red) begin
				$error("red_out: expected %0d, actual %0d", want.red, r);
				errors++;
			end
			if (last !== want.last) begin
				$error("frame_last: expected %0d, actual %0d", want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  pixel_valid;
	logic                  pixel_stall;
	logic                  command;
	logic [CH_W-1:0]       blue_in;
	logic [CH_W-1:0]       green_in;
	logic [CH_W-1:0]       red_in;
	logic                  result_valid;
	logic                  result_stall;
	logic [CH_W-1:0]       blue_out;
	logic [CH_W-1:0]       green_out;
	logic [CH_W-1:0]       red_out;
	logic                  frame_last;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	blur_scoreboard sb = new();
	int             cycle_count = 0;
	int             stretch_left [2] = '{0, 0};
	bit             calm [2] = '{1'b0, 1'b0};
	bit             long_hold = 1'b0;
	bit             fast_lane = 1'b0;

	box_blur_3x3_edge_average_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.command      (command),
		.blue_in      (blue_in),
		.green_in     (green_in),
		.red_in       (red_in),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.blue_out     (blue_out),
		.green_out    (green_out),
		.red_out      (red_out),
		.frame_last   (frame_last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 50 MHz clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// timeout guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// transfer monitors: results are checked before new beats are noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall)
				sb.check_result(blue_out, green_out, red_out, frame_last);
			if (pixel_valid && !pixel_stall)
				sb.note_beat(command, blue_in, green_in, red_in);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
		end
	end

	// per-transfer wait, in random stretches that are either busy or gap-free
	function automatic int draw_wait(int side);
		if (stretch_left[side] == 0) begin
			stretch_left[side] = $urandom_range(10, 60);
			calm[side] = ($urandom_range(0, 3) == 0);
		end
		stretch_left[side]--;
		return calm[side] ? 0 : $urandom_range(0, 16);
	endfunction

	// channel value, weighted toward the extremes
	function automatic logic [CH_W-1:0] rand_chan();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return CH_W'($urandom_range(0, 255));
		endcase
	endfunction

	// result side: random stall before each transfer, one long hold on request
	initial begin
		int hold;
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				hold = LONG_HOLD;
				long_hold = 1'b0;
			end else begin
				hold = draw_wait(RECEIVER);
			end
			@(negedge clk);
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
		end
	end

	// one beat on the pixel channel; returns right after its transfer
	task automatic send_beat(logic cmd, logic [CH_W-1:0] b, logic [CH_W-1:0] g,
			logic [CH_W-1:0] r);
		int gap;
		gap = fast_lane ? 0 : draw_wait(SENDER);
		@(negedge clk);
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pixel_valid <= 1'b1;
		command     <= cmd;
		blue_in     <= b;
		green_in    <= g;
		red_in      <= r;
		do @(posedge clk); while (pixel_stall);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// idle the input, wait for all predicted pixels, then let the pipeline settle
	task automatic drain();
		@(negedge clk);
		pixel_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one frame at the current size: pixels, then width+1 flush beats, optional
	// out-of-phase noise, optionally cut short
	task automatic run_frame(bit broken, int noise_pct, inout int beat_count);
		int w, h, total, limit;
		w = sb.active_width();
		h = sb.active_height();
		total = w * h;
		limit = broken ? $urandom_range(1, total + w) : total + w + 1;
		for (int i = 0; i < limit; i++) begin
			logic flushing;
			flushing = (i >= total);
			if ($urandom_range(0, 99) < noise_pct)
				send_beat(flushing ? CMD_PIXEL : CMD_FLUSH, rand_chan(), rand_chan(), rand_chan());
			send_beat(flushing ? CMD_FLUSH : CMD_PIXEL, rand_chan(), rand_chan(), rand_chan());
			beat_count++;
		end
	endtask

	// main stimulus
	initial begin
		int directed_items, big_items, random_items, frame_no, mode, noise;
		logic [CFG_DATA_W-1:0] w_data, h_data;
		bit broken;
		directed_items = 0;
		big_items      = 0;
		random_items   = 0;
		frame_no       = 0;
		arst_n      = 1'b0;
		pixel_valid = 1'b0;
		command     = CMD_PIXEL;
		blue_in     = '0;
		green_in    = '0;
		red_in      = '0;
		cfg_valid   = 1'b0;
		cfg_index   = REG_FRAME_WIDTH;
		cfg_data    = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset-size frame: stray flush during pixels, start of first row only
		send_beat(CMD_FLUSH, '1, '1, '1);
		repeat (3) begin
			send_beat(CMD_PIXEL, rand_chan(), rand_chan(), rand_chan());
			directed_items++;
		end
		drain();

		// zero width and height read as a 1x1 frame; stray pixel during flush
		write_cfg(REG_FRAME_WIDTH, '0);
		write_cfg(REG_FRAME_HEIGHT, '0);
		send_beat(CMD_PIXEL, '1, '0, 8'h80);
		send_beat(CMD_PIXEL, '0, '1, '0);
		send_beat(CMD_FLUSH, '0, '0, '0);
		send_beat(CMD_FLUSH, '1, '1, '1);
		directed_items += 3;
		drain();

		// 3x2 frame; writes to unmapped indexes mid-frame must not abort it
		write_cfg(REG_FRAME_WIDTH, CFG_DATA_W'(3));
		write_cfg(REG_FRAME_HEIGHT, CFG_DATA_W'(2));
		repeat (3) send_beat(CMD_PIXEL, '1, '1, '1);
		drain();
		write_cfg(REG_UNUSED_LO, '1);
		write_cfg(REG_UNUSED_HI, '0);
		for (int i = 0; i < 3; i++)
			send_beat(CMD_PIXEL, (i == 1) ? '1 : '0, CH_W'(1), CH_W'(2));
		repeat (4) send_beat(CMD_FLUSH, rand_chan(), rand_chan(), rand_chan());
		directed_items += 10;
		drain();

		// oversize width saturates at the line store depth: one full row of a
		// one-row frame, then flush beats that only fit the phase if the row
		// ended there; the open frame is aborted by the next register write
		fast_lane = 1'b1;
		write_cfg(REG_FRAME_WIDTH, '1);
		write_cfg(REG_FRAME_HEIGHT, CFG_DATA_W'(1));
		for (int i = 0; i < MAX_WIDTH; i++) begin
			send_beat(CMD_PIXEL, rand_chan(), rand_chan(), rand_chan());
			big_items++;
		end
		repeat (SAT_FLUSH_BEATS) begin
			send_beat(CMD_FLUSH, '0, '0, '0);
			big_items++;
		end
		drain();
		fast_lane = 1'b0;

		// random frames, mostly well-formed, some with noise or cut short
		while (random_items < RANDOM_ITEMS) begin
			frame_no++;
			case ($urandom_range(0, 19))
				0: w_data = '0;
				1, 2, 3, 4: w_data = CFG_DATA_W'($urandom_range(7, 24));
				default: w_data = CFG_DATA_W'($urandom_range(1, 6));
			endcase
			// bit 11 lies outside the width register
			w_data[CFG_DATA_W-1] = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 19))
				0: h_data = '0;
				1, 2, 3: h_data = CFG_DATA_W'($urandom_range(7, 12));
				default: h_data = CFG_DATA_W'($urandom_range(1, 6));
			endcase
			mode   = $urandom_range(0, 3);
			broken = ($urandom_range(0, 7) == 0);
			noise  = ($urandom_range(0, 2) == 0) ? 15 : 0;
			if (frame_no == 1) mode = 2;
			// receiver holds off while a larger frame streams in
			if (frame_no == PRESSURE_FRAME) begin
				w_data    = CFG_DATA_W'(20);
				h_data    = CFG_DATA_W'(10);
				mode      = 2;
				broken    = 1'b0;
				long_hold = 1'b1;
			end
			case (mode)
				0: write_cfg(REG_FRAME_WIDTH, w_data);
				1: write_cfg(REG_FRAME_HEIGHT, h_data);
				2: begin
					write_cfg(REG_FRAME_WIDTH, w_data);
					write_cfg(REG_FRAME_HEIGHT, h_data);
				end
				default: begin
					write_cfg(REG_FRAME_HEIGHT, h_data);
					write_cfg(REG_FRAME_WIDTH, w_data);
				end
			endcase
			if ($urandom_range(0, 5) == 0)
				write_cfg($urandom_range(0, 1) ? REG_UNUSED_HI : REG_UNUSED_LO,
					CFG_DATA_W'($urandom));
			run_frame(broken, noise, random_items);
			drain();
		end

		if (sb.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
